[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define PWMM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PWMM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pwmm_pkg.sv]
// ----------------------------------------------------------------------------
// pwmm_pkg
// Types, widths and codes shared by the PWM mapper modules.
// ----------------------------------------------------------------------------
package pwmm_pkg;

  localparam int CMD_W           = 20;  // signed Q11.8 command
  localparam int WID_W           = 24;  // unsigned pulse width
  localparam int ROW_IDX_W       = 8;
  localparam int ENTRY_CNT_W     = 9;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 24;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int ROW_W           = CMD_W + WID_W;
  localparam int PROD_W          = CMD_W + WID_W;  // |dy| * (c - x0)
  localparam int CNT_W           = 6;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(CMD_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CONV = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_ACT_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 1'd1;

  typedef logic signed [CMD_W-1:0] pwmm_cmd_t;
  typedef logic        [WID_W-1:0] pwmm_wid_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SEARCH,
    ST_MATH,
    ST_DONE
  } pwmm_state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_DIV,
    PH_FIN
  } pwmm_phase_t;

  typedef struct packed {
    logic      start;
    pwmm_cmd_t c;
    pwmm_cmd_t x0;
    pwmm_cmd_t x1;
    pwmm_wid_t y0;
    pwmm_wid_t y1;
  } pwmm_interp_req_t;

  typedef struct packed {
    logic      done;
    pwmm_wid_t width;
  } pwmm_interp_rsp_t;

endpackage

[rtl/pwmm_ram.sv]
// ----------------------------------------------------------------------------
// pwmm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pwmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/pwmm_interp.sv]
// ----------------------------------------------------------------------------
// pwmm_interp
// Bit-serial linear interpolation: shift-add multiply, restoring divide and
// round-half-up correction between two breakpoint rows.
// ----------------------------------------------------------------------------
module pwmm_interp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pwmm_pkg::pwmm_interp_req_t req,
  output pwmm_pkg::pwmm_interp_rsp_t rsp
);
  import pwmm_pkg::*;

  pwmm_phase_t        phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PROD_W:0]    p_r, p_nxt;
  logic [CMD_W-1:0]   rem_r, rem_nxt;
  logic [CMD_W-1:0]   den_r, den_nxt;
  logic [WID_W-1:0]   mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  pwmm_wid_t          y0_r, y0_nxt;

  logic [CMD_W:0]     t_diff, den_diff;
  logic [WID_W:0]     dy;
  logic [WID_W:0]     mul_sum;
  logic [CMD_W:0]     trial;
  logic               ge;
  logic [CMD_W:0]     rem2;
  logic               adj;
  logic [WID_W+1:0]   fin;

  // Both differences are positive by construction of the search.
  assign t_diff   = {req.c[CMD_W-1], req.c} - {req.x0[CMD_W-1], req.x0};
  assign den_diff = {req.x1[CMD_W-1], req.x1} - {req.x0[CMD_W-1], req.x0};
  assign dy       = {1'b0, req.y1} - {1'b0, req.y0};

  assign mul_sum = p_r[PROD_W:CMD_W] + (p_r[0] ? {1'b0, mag_r} : '0);
  assign trial   = {rem_r, p_r[PROD_W-1]};
  assign ge      = trial >= {1'b0, den_r};

  // Magnitude quotient and remainder give the rounded value; on a negative slope
  // an exact half rounds toward the larger width, as on a positive one.
  assign rem2 = {rem_r, 1'b0};
  assign adj  = neg_r ? ((rem_r != '0) && (rem2 > {1'b0, den_r})) : (rem2 >= {1'b0, den_r});
  assign fin  = neg_r ? ({2'b00, y0_r} - {2'b00, p_r[WID_W-1:0]} - (WID_W+2)'(adj))
                      : ({2'b00, y0_r} + {2'b00, p_r[WID_W-1:0]} + (WID_W+2)'(adj));

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (req.start) begin
          phase_nxt = PH_MUL;
        end
      end
      PH_MUL: begin
        if (cnt_r == MUL_LAST) begin
          phase_nxt = PH_DIV;
        end
      end
      PH_DIV: begin
        if (cnt_r == DIV_LAST) begin
          phase_nxt = PH_FIN;
        end
      end
      PH_FIN:  phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    p_nxt   = p_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    y0_nxt  = y0_r;
    case (phase_r)
      PH_IDLE: begin
        if (req.start) begin
          cnt_nxt = '0;
          p_nxt   = {{(WID_W+1){1'b0}}, t_diff[CMD_W-1:0]};
          den_nxt = den_diff[CMD_W-1:0];
          neg_nxt = dy[WID_W];
          mag_nxt = dy[WID_W] ? WID_W'(-dy) : dy[WID_W-1:0];
          y0_nxt  = req.y0;
        end
      end
      PH_MUL: begin
        p_nxt   = {1'b0, mul_sum, p_r[CMD_W-1:1]};
        cnt_nxt = (cnt_r == MUL_LAST) ? '0 : cnt_r + 1'b1;
        rem_nxt = '0;
      end
      PH_DIV: begin
        rem_nxt = ge ? CMD_W'(trial - {1'b0, den_r}) : trial[CMD_W-1:0];
        p_nxt   = {1'b0, p_r[PROD_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      PH_FIN: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_comb begin
    rsp.done  = (phase_r == PH_FIN);
    rsp.width = fin[WID_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    y0_r  <= y0_nxt;
  end

endmodule

[rtl/piecewise_linear_pwm_mapper_core.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_pwm_mapper_core
// Maps a thrust command to a PWM pulse width through a breakpoint table with
// linear interpolation between rows.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake         Word
//  in       sink       in_valid/stall    load row or convert command
//  out      source     out_valid/stall   pulse width
//  cfg      sink       cfg_valid/ready   register index and data
//
// A load word never stalls the input. A zero command goes straight to the
// output with the no-action width. Other commands read the first row, then the
// last, and saturate to that row's width if outside them; otherwise the linear
// search reads one row per cycle from the single RAM read port, then a
// bit-serial multiply and a restoring divide follow, one bit at a time. Reset
// is synchronous; table contents stay undefined until written. A finished
// result waits in the output register while the next input word is accepted.
module piecewise_linear_pwm_mapper_core #(
  parameter int TABLE_DEPTH = pwmm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [pwmm_pkg::ROW_IDX_W-1:0]    in_row_index,
  input  logic signed [pwmm_pkg::CMD_W-1:0] in_row_command,
  input  logic [pwmm_pkg::WID_W-1:0]        in_row_width,
  input  logic signed [pwmm_pkg::CMD_W-1:0] in_command,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pwmm_pkg::WID_W-1:0]        out_pulse_width,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwmm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pwmm_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  pwmm_state_t            state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pwmm_wid_t              out_pw_r, out_pw_nxt;
  pwmm_wid_t              no_act_r;
  logic [ENTRY_CNT_W-1:0] entry_count_r;
  pwmm_cmd_t              cmd_r, cmd_nxt;
  pwmm_cmd_t              x0_r, x0_nxt;
  pwmm_wid_t              y0_r, y0_nxt;
  pwmm_wid_t              res_r, res_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;

  logic                   in_acc, conv_acc, ram_we, rd_en, out_free, search_go, row_ok;
  logic [AW-1:0]          rd_addr, last_idx;
  logic [ROW_W-1:0]       rd_data;
  logic [31:0]            ec_w;
  pwmm_cmd_t              row_cmd;
  pwmm_wid_t              row_wid;
  pwmm_interp_req_t       ireq;
  pwmm_interp_rsp_t       irsp;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_pulse_width = out_pw_r;

  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign conv_acc = in_acc && (in_kind == KIND_CONV);
  assign row_ok   = 32'(in_row_index) < 32'(TABLE_DEPTH);
  assign ram_we   = in_acc && (in_kind == KIND_LOAD) && row_ok;
  assign out_free = !out_valid_r || !out_stall;

  assign row_cmd = rd_data[ROW_W-1:WID_W];
  assign row_wid = rd_data[WID_W-1:0];

  // Effective last row: a count of zero acts as one, large counts saturate.
  assign ec_w = 32'(entry_count_r);
  always_comb begin
    if (ec_w == 32'd0) begin
      last_idx = '0;
    end else if (ec_w > 32'(TABLE_DEPTH)) begin
      last_idx = AW'(TABLE_DEPTH - 1);
    end else begin
      last_idx = AW'(ec_w - 32'd1);
    end
  end

  assign search_go = (idx_r < last_idx) && (cmd_r > row_cmd);

  pwmm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_row_index)),
    .wdata ({in_row_command, in_row_width}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  pwmm_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ireq),
    .rsp   (irsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (conv_acc) begin
          state_nxt = (in_command == '0) ? ST_DONE : ST_FIRST;
        end
      end
      ST_FIRST:  state_nxt = (cmd_r <= row_cmd) ? ST_DONE : ST_LAST;
      ST_LAST:   state_nxt = (cmd_r >= row_cmd) ? ST_DONE : ST_SEARCH;
      ST_SEARCH: state_nxt = search_go ? ST_SEARCH : ST_MATH;
      ST_MATH:   state_nxt = irsp.done ? ST_DONE : ST_MATH;
      ST_DONE:   state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = '0;
    cmd_nxt       = cmd_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    res_nxt       = res_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pw_nxt    = out_pw_r;
    ireq.start    = 1'b0;
    ireq.c        = cmd_r;
    ireq.x0       = x0_r;
    ireq.x1       = row_cmd;
    ireq.y0       = y0_r;
    ireq.y1       = row_wid;
    case (state_r)
      ST_IDLE: begin
        if (conv_acc) begin
          cmd_nxt = in_command;
          res_nxt = no_act_r;
          rd_en   = 1'b1;
        end
      end
      ST_FIRST: begin
        x0_nxt  = row_cmd;
        y0_nxt  = row_wid;
        res_nxt = row_wid;
        rd_en   = 1'b1;
        rd_addr = last_idx;
      end
      ST_LAST: begin
        res_nxt = row_wid;
        rd_en   = 1'b1;
        rd_addr = AW'(1);
        idx_nxt = AW'(1);
      end
      ST_SEARCH: begin
        // The next row is read while this one is compared.
        if (search_go) begin
          x0_nxt  = row_cmd;
          y0_nxt  = row_wid;
          idx_nxt = AW'(idx_r + 1'b1);
          rd_en   = 1'b1;
          rd_addr = AW'(idx_r + 1'b1);
        end else begin
          ireq.start = 1'b1;
        end
      end
      ST_MATH: begin
        if (irsp.done) begin
          res_nxt = irsp.width;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pw_nxt    = res_r;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      no_act_r      <= '0;
      entry_count_r <= ENTRY_CNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NO_ACT_WIDTH: no_act_r      <= cfg_data[WID_W-1:0];
          CFG_ENTRY_COUNT:  entry_count_r <= cfg_data[ENTRY_CNT_W-1:0];
          default:          entry_count_r <= entry_count_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    x0_r     <= x0_nxt;
    y0_r     <= y0_nxt;
    res_r    <= res_nxt;
    idx_r    <= idx_nxt;
    out_pw_r <= out_pw_nxt;
  end

endmodule

[rtl/pwmm_checker.sv]
// ----------------------------------------------------------------------------
// pwmm_checker
// Port-level checks on the PWM mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwmm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_kind,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [pwmm_pkg::WID_W-1:0]        out_pulse_width
);
  import pwmm_pkg::*;

  `PWMM_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "out word dropped while stalled")
  `PWMM_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_pulse_width), "stalled out word changed")
  `PWMM_ASSERT(a_load_one_cycle, clk, rst_n, in_valid && !in_stall && (in_kind == KIND_LOAD) |=> !in_stall, "load word held the input")
  `PWMM_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_valid, "out word present after reset")

endmodule

bind piecewise_linear_pwm_mapper_core pwmm_checker u_pwmm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_kind         (in_kind),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pulse_width (out_pulse_width)
);

[verif/piecewise_linear_pwm_mapper_core_tb.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_pwm_mapper_core_tb
// Self-checking bench for the PWM mapper. It loads breakpoint rows, converts
// commands, and checks every pulse width against its own table lookup and
// rounded interpolation. It covers directed corner cases, the limits of the
// row count, a full 256-row table, a long output hold-off and random traffic
// under several idle and stall mixes.
// ----------------------------------------------------------------------------
module piecewise_linear_pwm_mapper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwmm_pkg::*;

  localparam int TABLE_DEPTH   = TABLE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 2000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_kind = KIND_LOAD;
  logic [ROW_IDX_W-1:0]   in_row_index = '0;
  pwmm_cmd_t              in_row_command = '0;
  pwmm_wid_t              in_row_width = '0;
  pwmm_cmd_t              in_command = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  pwmm_wid_t              out_pulse_width;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_NO_ACT_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Local copy of the table and registers, updated as words are accepted.
  pwmm_cmd_t              bp_cmd [TABLE_DEPTH];
  pwmm_wid_t              bp_wid [TABLE_DEPTH];
  pwmm_wid_t              model_no_act = '0;
  logic [ENTRY_CNT_W-1:0] model_entry_cnt = 9'd1;

  pwmm_wid_t              pending_widths [$];
  pwmm_wid_t              expected_width;
  int                     mismatch_count = 0;

  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  int                     hold_tag = 0;
  int                     hold_seen = 0;
  int                     hold_left = 0;

  piecewise_linear_pwm_mapper_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_row_index    (in_row_index),
    .in_row_command  (in_row_command),
    .in_row_width    (in_row_width),
    .in_command      (in_command),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pulse_width (out_pulse_width),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stall, or a long hold-off whenever the test bumps hold_tag.
  always @(negedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_widths.size() == 0) begin
        $error("unexpected pulse_width word: actual %0d", out_pulse_width);
        mismatch_count++;
      end else begin
        expected_width = pending_widths.pop_front();
        if (out_pulse_width !== expected_width) begin
          $error("pulse_width mismatch: expected %0d, actual %0d",
                 expected_width, out_pulse_width);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int effective_rows();
    if (model_entry_cnt == 0) return 1;
    if (model_entry_cnt > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(model_entry_cnt);
  endfunction

  function automatic pwmm_wid_t interpolate_width(pwmm_cmd_t c);
    int     n;
    int     i;
    longint x0, x1, y0, y1, num, den, t, d2, q;
    if (c == 0) return model_no_act;
    n = effective_rows();
    if (c <= bp_cmd[0]) return bp_wid[0];
    if (c >= bp_cmd[n-1]) return bp_wid[n-1];
    i = 1;
    while (i < n - 1 && c > bp_cmd[i]) i++;
    x0 = bp_cmd[i-1];
    x1 = bp_cmd[i];
    y0 = bp_wid[i-1];
    y1 = bp_wid[i];
    den = x1 - x0;
    if (den <= 0) return bp_wid[i-1];
    num = (y1 - y0) * (longint'(c) - x0);
    // Round half up: floor((2*num + den) / (2*den)).
    t  = 2 * num + den;
    d2 = 2 * den;
    q  = (t >= 0) ? t / d2 : -((-t + d2 - 1) / d2);
    return pwmm_wid_t'(y0 + q);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic kind, input logic [ROW_IDX_W-1:0] row,
                           input pwmm_cmd_t rcmd, input pwmm_wid_t rwid,
                           input pwmm_cmd_t cmd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_row_index   <= row;
    in_row_command <= rcmd;
    in_row_width   <= rwid;
    in_command     <= cmd;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_LOAD) begin
      bp_cmd[row] = rcmd;
      bp_wid[row] = rwid;
    end else begin
      pending_widths.insert(pending_widths.size(), interpolate_width(cmd));
    end
    @(negedge clk);
  endtask

  task automatic load_row(input int row, input int x, input int y);
    send_word(KIND_LOAD, ROW_IDX_W'(row), pwmm_cmd_t'(x), pwmm_wid_t'(y),
              pwmm_cmd_t'($urandom));
  endtask

  task automatic convert_cmd(input int c);
    send_word(KIND_CONV, ROW_IDX_W'($urandom), pwmm_cmd_t'($urandom),
              pwmm_wid_t'($urandom), pwmm_cmd_t'(c));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_widths.size() != 0) @(negedge clk);
    // A load word may still be in flight with nothing expected.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_NO_ACT_WIDTH) model_no_act = data;
    else model_entry_cnt = data[ENTRY_CNT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Rows spaced so that a mostly ascending table spans the full command range.
  function automatic pwmm_cmd_t ordered_cmd(int row);
    return pwmm_cmd_t'(-524288 + row * 4096 + int'($urandom_range(0, 4095)));
  endfunction

  function automatic pwmm_cmd_t pick_command();
    int     n;
    int     sel;
    longint lo, hi;
    n   = effective_rows();
    sel = $urandom_range(0, 99);
    lo  = (bp_cmd[0] < bp_cmd[n-1]) ? bp_cmd[0] : bp_cmd[n-1];
    hi  = (bp_cmd[0] < bp_cmd[n-1]) ? bp_cmd[n-1] : bp_cmd[0];
    if (sel < 5) return '0;
    if (sel < 12) return bp_cmd[$urandom_range(0, n - 1)];
    if (sel < 22) return pwmm_cmd_t'($urandom);
    return pwmm_cmd_t'(lo + longint'($urandom_range(0, int'(hi - lo))));
  endfunction

  task automatic test_directed_table();
    // Reset values: zero word gives 0, a single row answers everything else.
    load_row(0, -512, 0);
    convert_cmd(0);
    convert_cmd(77);
    load_row(1, -256, 1);
    load_row(2, 768, 60);
    load_row(3, 1792, 9);
    load_row(4, 524287, 24'hFFFFFF);
    wait_idle();
    write_reg(CFG_NO_ACT_WIDTH, 24'hFFFFFF);
    write_reg(CFG_ENTRY_COUNT, 24'd5);
    convert_cmd(0);
    convert_cmd(-524288);
    convert_cmd(-512);
    convert_cmd(-513);
    convert_cmd(524287);
    convert_cmd(524286);
    convert_cmd(-384);    // exact half on a rising segment
    convert_cmd(-385);
    convert_cmd(-256);    // exactly on a breakpoint
    convert_cmd(1280);    // exact half on a falling segment
    convert_cmd(1000);
    convert_cmd(1);
    convert_cmd(-1);
    convert_cmd(100000);
    wait_idle();
  endtask

  task automatic test_entry_count_limits();
    // A count of zero behaves as a single row.
    write_reg(CFG_NO_ACT_WIDTH, 24'd0);
    write_reg(CFG_ENTRY_COUNT, 24'd0);
    convert_cmd(0);
    convert_cmd(524287);
    convert_cmd(-524288);
    convert_cmd(12345);
    wait_idle();
    write_reg(CFG_ENTRY_COUNT, 24'd1);
    convert_cmd(-384);
    convert_cmd(-600);
    wait_idle();
    write_reg(CFG_ENTRY_COUNT, 24'd2);
    convert_cmd(-384);
    convert_cmd(1000);
    convert_cmd(-600);
    wait_idle();
  endtask

  task automatic test_full_table();
    int counts [3] = '{256, 300, 511};
    for (int r = 0; r < TABLE_DEPTH; r++) begin
      send_word(KIND_LOAD, ROW_IDX_W'(r),
                ($urandom_range(0, 9) == 0) ? pwmm_cmd_t'($urandom) : ordered_cmd(r),
                pwmm_wid_t'($urandom), pwmm_cmd_t'($urandom));
    end
    wait_idle();
    write_reg(CFG_NO_ACT_WIDTH, CFG_DATA_W'($urandom));
    // Counts above the table depth use every row.
    foreach (counts[k]) begin
      write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(counts[k]));
      repeat (5) convert_cmd(int'(pick_command()));
      convert_cmd(int'(bp_cmd[TABLE_DEPTH-1]) - 1);
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CFG_ENTRY_COUNT, 24'd6);
    hold_tag++;
    repeat (30) convert_cmd(int'(pick_command()));
    wait_idle();
  endtask

  task automatic random_items(input int count);
    int n;
    int row;
    n = effective_rows();
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        row = ($urandom_range(0, 9) < 8) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
        send_word(KIND_LOAD, ROW_IDX_W'(row),
                  ($urandom_range(0, 9) < 8) ? ordered_cmd(row) : pwmm_cmd_t'($urandom),
                  pwmm_wid_t'($urandom), pwmm_cmd_t'($urandom));
      end else begin
        convert_cmd(int'(pick_command()));
      end
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int idle_mix  [4] = '{0, 81, 0, 14};
    int stall_mix [4] = '{0, 0, 81, 14};
    foreach (idle_mix[p]) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      write_reg(CFG_NO_ACT_WIDTH, CFG_DATA_W'($urandom));
      write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'($urandom_range(2, 12)));
      random_items(80);
      write_reg(CFG_NO_ACT_WIDTH, CFG_DATA_W'($urandom));
      write_reg(CFG_ENTRY_COUNT, ($urandom_range(0, 3) == 0) ?
                CFG_DATA_W'($urandom_range(17, 256)) : CFG_DATA_W'($urandom_range(1, 16)));
      random_items(80);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed_table();
    test_entry_count_limits();
    test_full_table();
    test_output_backpressure();
    test_random_traffic();
    if (pending_widths.size() != 0)
      $error("%0d pulse_width words never arrived", pending_widths.size());
    if (mismatch_count == 0 && pending_widths.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/pwmm_pkg.sv
rtl/pwmm_ram.sv
rtl/pwmm_interp.sv
rtl/piecewise_linear_pwm_mapper_core.sv
rtl/pwmm_checker.sv
verif/piecewise_linear_pwm_mapper_core_tb.sv
